// ===== hw/rtl/efrh_pkg.sv =====
package efrh_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned ANGLE_W = 14;
	localparam int unsigned STATUS_W = 4;
	localparam int unsigned FRAME_W = 24;

	localparam logic [ADDR_W-3:0] REG_TIMEOUT = 1'b0;
	localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd17000;

	localparam logic [1:0] OP_TRIGGER = 2'd0;
	localparam logic [1:0] OP_FRAME_DONE = 2'd1;
	localparam logic [1:0] OP_XFER_ERROR = 2'd2;
	localparam logic [1:0] OP_TIMEOUT_CHECK = 2'd3;

	localparam int unsigned ANGLE_LSB = 10;
	localparam int unsigned STATUS_LSB = 6;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        timestamp;
		logic [FRAME_W-1:0] frame_word;
		logic               start_failed;
	} req_t;

	typedef struct packed {
		logic                done_flag;
		logic                sample_valid;
		logic [ANGLE_W-1:0]  angle_code;
		logic [STATUS_W-1:0] status_bits;
		logic [31:0]         sample_sequence;
		logic [31:0]         sample_time;
		logic [31:0]         valid_total;
		logic [31:0]         status_fault_total;
		logic [31:0]         errors_in_row;
		logic [31:0]         transfer_fault_total;
		logic [31:0]         missed_total;
		logic [31:0]         start_fault_total;
	} res_t;

	typedef enum logic [1:0] {
		CMD_TRIGGER = 2'd0,
		CMD_FRAME   = 2'd1,
		CMD_ERROR   = 2'd2,
		CMD_TIMEOUT = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [31:0]         timestamp;
		logic [ANGLE_W-1:0]  angle_code;
		logic [STATUS_W-1:0] status_bits;
		logic                status_clear;
		logic                start_failed;
	} cmd_t;

endpackage

// ===== hw/rtl/encoder_frame_reader_health_top.sv =====
// angle-sensor frame reader with health counters
// request channel: req_valid / req_stall / req carry one event (trigger, frame
// done, transfer error, timeout check); taken when req_valid high, req_stall low
// result channel: res_valid / res_stall / res carry exactly one result per event,
// in request order, with every health counter as it stands after the event
// decode runs on the request side and feeds a queue of QUEUE_DEPTH entries; the
// counter unit pops one event a cycle while the result register is free or not stalled, and writes the result register
// a taken request is first written to the queue and is popped into the result
// register from there, even when the queue is empty and the result register is free
// throughput: one event per cycle while the result register is not held by res_stall
// res_stall holds the result register; the queue then fills and req_stall rises
// only once it is full, so requests keep flowing until QUEUE_DEPTH entries wait
// reset: queue empty, result register empty, counters and busy cleared,
// timeout_cycles back to 17000
// apb: timeout_cycles at byte address 0, written on the access cycle
module encoder_frame_reader_health_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  efrh_pkg::req_t                req,
	output logic                          res_valid,
	input  logic                          res_stall,
	output efrh_pkg::res_t                res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efrh_pkg::ADDR_W-1:0]   paddr,
	input  logic [efrh_pkg::DATA_W-1:0]   pwdata,
	output logic [efrh_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	efrh_pkg::cmd_t cmd_in;
	efrh_pkg::cmd_t cmd_out;
	logic [efrh_pkg::DATA_W-1:0] timeout_q;
	logic           reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[efrh_pkg::ADDR_W-1:2] == efrh_pkg::REG_TIMEOUT);
	assign prdata  = reg_hit ? timeout_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= efrh_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			timeout_q <= pwdata;
		end
	end

	efrh_front u_front (
		.req_valid (req_valid),
		.full      (full),
		.req       (req),
		.req_stall (req_stall),
		.push      (push),
		.cmd       (cmd_in)
	);

	efrh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd_in),
		.pop       (pop),
		.pop_data  (cmd_out),
		.full      (full),
		.empty     (empty)
	);

	efrh_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.timeout_cycles (timeout_q),
		.empty          (empty),
		.cmd            (cmd_out),
		.pop            (pop),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.res            (res)
	);

endmodule

// ===== hw/rtl/efrh_front.sv =====
module efrh_front (
	input  logic          req_valid,
	input  logic          full,
	input  efrh_pkg::req_t req,
	output logic          req_stall,
	output logic          push,
	output efrh_pkg::cmd_t cmd
);

	always_comb begin
		unique case (req.opcode)
			efrh_pkg::OP_TRIGGER:       cmd.kind = efrh_pkg::CMD_TRIGGER;
			efrh_pkg::OP_FRAME_DONE:    cmd.kind = efrh_pkg::CMD_FRAME;
			efrh_pkg::OP_XFER_ERROR:    cmd.kind = efrh_pkg::CMD_ERROR;
			efrh_pkg::OP_TIMEOUT_CHECK: cmd.kind = efrh_pkg::CMD_TIMEOUT;
			default:                    cmd.kind = efrh_pkg::CMD_TIMEOUT;
		endcase
		cmd.timestamp    = req.timestamp;
		cmd.angle_code   = req.frame_word[efrh_pkg::ANGLE_LSB +: efrh_pkg::ANGLE_W];
		cmd.status_bits  = req.frame_word[efrh_pkg::STATUS_LSB +: efrh_pkg::STATUS_W];
		cmd.status_clear = (cmd.status_bits == '0);
		cmd.start_failed = req.start_failed;
	end

	assign req_stall = full;
	assign push      = req_valid && !full;

endmodule

// ===== hw/rtl/efrh_queue.sv =====
module efrh_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  efrh_pkg::cmd_t push_data,
	input  logic           pop,
	output efrh_pkg::cmd_t pop_data,
	output logic           full,
	output logic           empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	efrh_pkg::cmd_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/efrh_back.sv =====
module efrh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    timeout_cycles,
	input  logic           empty,
	input  efrh_pkg::cmd_t cmd,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_stall,
	output efrh_pkg::res_t res
);

	logic        busy_q;
	logic [31:0] start_stamp_q;
	logic [31:0] seq_q;
	logic [31:0] good_q;
	logic [31:0] status_fault_q;
	logic [31:0] run_q;
	logic [31:0] xfer_fault_q;
	logic [31:0] missed_q;
	logic [31:0] start_fault_q;
	logic        res_valid_q;
	efrh_pkg::res_t res_q;

	logic        busy_d;
	logic [31:0] start_stamp_d;
	logic [31:0] seq_d;
	logic [31:0] good_d;
	logic [31:0] status_fault_d;
	logic [31:0] run_d;
	logic [31:0] xfer_fault_d;
	logic [31:0] missed_d;
	logic [31:0] start_fault_d;
	logic [31:0] elapsed;
	efrh_pkg::res_t res_d;

	assign pop       = !empty && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign elapsed   = cmd.timestamp - start_stamp_q;

	always_comb begin
		busy_d         = busy_q;
		start_stamp_d  = start_stamp_q;
		seq_d          = seq_q;
		good_d         = good_q;
		status_fault_d = status_fault_q;
		run_d          = run_q;
		xfer_fault_d   = xfer_fault_q;
		missed_d       = missed_q;
		start_fault_d  = start_fault_q;
		res_d          = '0;
		unique case (cmd.kind)
			efrh_pkg::CMD_TRIGGER: begin
				if (busy_q) begin
					missed_d = missed_q + 32'd1;
				end else begin
					start_stamp_d = cmd.timestamp;
					if (cmd.start_failed) begin
						start_fault_d = start_fault_q + 32'd1;
					end else begin
						busy_d          = 1'b1;
						res_d.done_flag = 1'b1;
					end
				end
			end
			efrh_pkg::CMD_FRAME: begin
				busy_d                = 1'b0;
				seq_d                 = seq_q + 32'd1;
				res_d.done_flag       = 1'b1;
				res_d.angle_code      = cmd.angle_code;
				res_d.status_bits     = cmd.status_bits;
				res_d.sample_sequence = seq_d;
				res_d.sample_time     = start_stamp_q;
				if (cmd.status_clear) begin
					res_d.sample_valid = 1'b1;
					good_d             = good_q + 32'd1;
					run_d              = '0;
				end else begin
					status_fault_d = status_fault_q + 32'd1;
					run_d          = run_q + 32'd1;
				end
			end
			efrh_pkg::CMD_ERROR: begin
				busy_d       = 1'b0;
				xfer_fault_d = xfer_fault_q + 32'd1;
			end
			efrh_pkg::CMD_TIMEOUT: begin
				if (busy_q && (elapsed >= timeout_cycles)) begin
					busy_d          = 1'b0;
					xfer_fault_d    = xfer_fault_q + 32'd1;
					res_d.done_flag = 1'b1;
				end
			end
			default: begin
				busy_d = busy_q;
			end
		endcase
		res_d.valid_total          = good_d;
		res_d.status_fault_total   = status_fault_d;
		res_d.errors_in_row        = run_d;
		res_d.transfer_fault_total = xfer_fault_d;
		res_d.missed_total         = missed_d;
		res_d.start_fault_total    = start_fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			start_stamp_q  <= '0;
			seq_q          <= '0;
			good_q         <= '0;
			status_fault_q <= '0;
			run_q          <= '0;
			xfer_fault_q   <= '0;
			missed_q       <= '0;
			start_fault_q  <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				busy_q         <= busy_d;
				start_stamp_q  <= start_stamp_d;
				seq_q          <= seq_d;
				good_q         <= good_d;
				status_fault_q <= status_fault_d;
				run_q          <= run_d;
				xfer_fault_q   <= xfer_fault_d;
				missed_q       <= missed_d;
				start_fault_q  <= start_fault_d;
				res_valid_q    <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== hw/rtl/efrh_checker.sv =====
module efrh_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input efrh_pkg::res_t res,
	input logic           pready
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.sample_valid |->
			res.done_flag && (res.status_bits == '0) && (res.errors_in_row == '0))
		else $error("valid sample with bad status or error run");

	// only a handled frame carries sample fields
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.done_flag |->
			!res.sample_valid && (res.angle_code == '0) && (res.status_bits == '0)
			&& (res.sample_sequence == '0) && (res.sample_time == '0))
		else $error("sample fields set on a result without done");

	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind encoder_frame_reader_health_top efrh_checker u_efrh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res),
	.pready    (pready)
);

// ===== tb/testbench.sv =====
module testbench;
	import efrh_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	encoder_frame_reader_health_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	req_t event_queue[$];
	res_t health_reports[$];
	res_t report_want;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;
	logic steady = 1'b0;
	logic [31:0] tick = '0;

	// shadow of the reader state
	logic reader_busy = 1'b0;
	logic [31:0] timeout_limit = TIMEOUT_RESET;
	logic [31:0] held_stamp = '0;
	logic [31:0] frame_seq = '0;
	logic [31:0] good_frames = '0;
	logic [31:0] status_faults = '0;
	logic [31:0] fault_run = '0;
	logic [31:0] transfer_faults = '0;
	logic [31:0] missed_triggers = '0;
	logic [31:0] start_faults = '0;

	function automatic res_t predict_health(req_t r);
		res_t o;
		logic [31:0] age;
		o = '0;
		age = r.timestamp - held_stamp;
		case (r.opcode)
			OP_TRIGGER: begin
				if (reader_busy) begin
					missed_triggers++;
				end else begin
					held_stamp = r.timestamp;
					if (r.start_failed) begin
						start_faults++;
					end else begin
						reader_busy = 1'b1;
						o.done_flag = 1'b1;
					end
				end
			end
			OP_FRAME_DONE: begin
				reader_busy = 1'b0;
				o.angle_code = r.frame_word[ANGLE_LSB +: ANGLE_W];
				o.status_bits = r.frame_word[STATUS_LSB +: STATUS_W];
				frame_seq++;
				o.sample_sequence = frame_seq;
				o.sample_time = held_stamp;
				o.done_flag = 1'b1;
				if (o.status_bits == '0) begin
					o.sample_valid = 1'b1;
					good_frames++;
					fault_run = '0;
				end else begin
					status_faults++;
					fault_run++;
				end
			end
			OP_XFER_ERROR: begin
				reader_busy = 1'b0;
				transfer_faults++;
			end
			OP_TIMEOUT_CHECK: begin
				if (reader_busy && age >= timeout_limit) begin
					reader_busy = 1'b0;
					transfer_faults++;
					o.done_flag = 1'b1;
				end
			end
		endcase
		o.valid_total = good_frames;
		o.status_fault_total = status_faults;
		o.errors_in_row = fault_run;
		o.transfer_fault_total = transfer_faults;
		o.missed_total = missed_triggers;
		o.start_fault_total = start_faults;
		return o;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
			fault_count++;
		end
	endfunction

	task automatic put_event(input logic [1:0] op, input logic [31:0] now,
			input logic [FRAME_W-1:0] frame, input logic failed);
		req_t r;
		r.opcode = op;
		r.timestamp = now;
		r.frame_word = frame;
		r.start_failed = failed;
		event_queue.push_back(r);
	endtask

	task automatic settle_reader();
		while (event_queue.size() != 0 || req_valid || health_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_timeout(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TIMEOUT, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		timeout_limit = value;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== value) begin
			$display("%0t timeout_cycles readback expected %0h actual %0h", $time, value, prdata);
			fault_count++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [FRAME_W-1:0] random_frame();
		logic [FRAME_W-1:0] f;
		f = $urandom;
		if ($urandom_range(1) == 0)
			f[STATUS_LSB +: STATUS_W] = '0;
		if ($urandom_range(9) == 0)
			f[ANGLE_LSB +: ANGLE_W] = $urandom_range(1) ? '1 : '0;
		return f;
	endfunction

	task automatic queue_random(input int unsigned count);
		int unsigned made;
		logic [31:0] stamp_at;
		logic [31:0] delta;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < 75) begin
				// transfer with random content, ended by a frame, an error or a timeout check
				tick = tick + $urandom_range(3000, 1);
				stamp_at = tick;
				put_event(OP_TRIGGER, stamp_at, $urandom, $urandom_range(15) == 0);
				made++;
				repeat ($urandom_range(2)) begin
					if (timeout_limit == 0)
						delta = 0;
					else if ($urandom_range(1))
						delta = timeout_limit - 1;
					else
						delta = $urandom_range(timeout_limit - 1);
					put_event(OP_TIMEOUT_CHECK, stamp_at + delta, $urandom, $urandom);
					made++;
				end
				case ($urandom_range(5))
					4: put_event(OP_XFER_ERROR, $urandom, $urandom, $urandom);
					5: begin
						delta = $urandom_range(1) ? timeout_limit
							: timeout_limit + $urandom_range(~timeout_limit);
						put_event(OP_TIMEOUT_CHECK, stamp_at + delta, $urandom, $urandom);
					end
					default: put_event(OP_FRAME_DONE, $urandom, random_frame(), $urandom);
				endcase
				made++;
			end else begin
				put_event($urandom_range(3), $urandom, $urandom, $urandom);
				made++;
			end
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("encoder_frame_reader_health_top regression: fail");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		if (req_valid && !req_stall)
			health_reports.push_back(predict_health(req));
		if (!req_valid || !req_stall) begin
			if (event_queue.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
				req <= event_queue.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (health_reports.size() == 0) begin
				$display("%0t result with none expected: expected none actual %0h", $time, res);
				fault_count++;
			end else begin
				report_want = health_reports.pop_front();
				compare_field("done_flag", report_want.done_flag, res.done_flag);
				compare_field("sample_valid", report_want.sample_valid, res.sample_valid);
				compare_field("angle_code", report_want.angle_code, res.angle_code);
				compare_field("status_bits", report_want.status_bits, res.status_bits);
				compare_field("sample_sequence", report_want.sample_sequence,
					res.sample_sequence);
				compare_field("sample_time", report_want.sample_time, res.sample_time);
				compare_field("valid_total", report_want.valid_total, res.valid_total);
				compare_field("status_fault_total", report_want.status_fault_total,
					res.status_fault_total);
				compare_field("errors_in_row", report_want.errors_in_row, res.errors_in_row);
				compare_field("transfer_fault_total", report_want.transfer_fault_total,
					res.transfer_fault_total);
				compare_field("missed_total", report_want.missed_total, res.missed_total);
				compare_field("start_fault_total", report_want.start_fault_total,
					res.start_fault_total);
			end
		end
		res_stall <= !steady && ($urandom_range(99) < 32);
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle-state events, start failure, refused triggers, timeout edges
		put_event(OP_FRAME_DONE, 32'h0, 24'h0, 1'b0);
		put_event(OP_XFER_ERROR, 32'h0, 24'h0, 1'b0);
		put_event(OP_TIMEOUT_CHECK, 32'hFFFF_FFFF, 24'h0, 1'b0);
		put_event(OP_TRIGGER, 32'hFFFF_FFFF, 24'h0, 1'b1);
		put_event(OP_FRAME_DONE, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
		put_event(OP_TRIGGER, 32'd100, 24'h0, 1'b0);
		put_event(OP_TRIGGER, 32'd200, 24'h0, 1'b0);
		put_event(OP_TRIGGER, 32'd300, 24'h0, 1'b1);
		put_event(OP_TIMEOUT_CHECK, 32'd100 + 32'd16999, 24'h0, 1'b0);
		put_event(OP_TIMEOUT_CHECK, 32'd100 + 32'd17000, 24'h0, 1'b0);
		put_event(OP_TRIGGER, 32'hFFFF_FF00, 24'h0, 1'b0);
		put_event(OP_TIMEOUT_CHECK, 32'hFFFF_FF00 + 32'd17000, 24'h0, 1'b0);
		put_event(OP_TRIGGER, 32'd5, 24'h0, 1'b0);
		put_event(OP_XFER_ERROR, 32'd6, 24'h0, 1'b0);
		put_event(OP_TRIGGER, 32'd7, 24'h0, 1'b0);
		put_event(OP_FRAME_DONE, 32'd8, 24'hFF_FC00, 1'b0);
		put_event(OP_FRAME_DONE, 32'd9, 24'h00_03C0, 1'b0);
		put_event(OP_FRAME_DONE, 32'd10, 24'h00_0040, 1'b0);
		put_event(OP_FRAME_DONE, 32'd11, 24'h00_003F, 1'b0);
		settle_reader();

		// zero timeout fires on any check while busy
		program_timeout(32'h0);
		put_event(OP_TRIGGER, 32'd50, 24'h0, 1'b0);
		put_event(OP_TIMEOUT_CHECK, 32'd50, 24'h0, 1'b0);
		settle_reader();

		program_timeout(32'hFFFF_FFFF);
		put_event(OP_TRIGGER, 32'd10, 24'h0, 1'b0);
		put_event(OP_TIMEOUT_CHECK, 32'd8, 24'h0, 1'b0);
		put_event(OP_TIMEOUT_CHECK, 32'd9, 24'h0, 1'b0);
		settle_reader();

		program_timeout(32'h0);
		queue_random(110);
		settle_reader();

		program_timeout(32'hFFFF_FFFF);
		tick = 32'hFFFF_8000;
		queue_random(110);
		settle_reader();

		// stretch with no idling on either side
		program_timeout($urandom_range(200, 1));
		steady = 1'b1;
		queue_random(170);
		settle_reader();
		@(negedge clk);
		steady = 1'b0;

		program_timeout(TIMEOUT_RESET);
		queue_random(150);
		settle_reader();

		program_timeout($urandom);
		queue_random(160);
		settle_reader();

		if (fault_count == 0)
			$display("encoder_frame_reader_health_top regression: pass");
		else
			$display("encoder_frame_reader_health_top regression: fail");
		$finish;
	end

endmodule
